>>> src/whp_pkg.sv
package whp_pkg;

  // parser phases
  typedef enum logic [3:0] {
    PH_RIFF  = 4'd0,
    PH_RSIZE = 4'd1,
    PH_WAVE  = 4'd2,
    PH_FMT   = 4'd3,
    PH_FSIZE = 4'd4,
    PH_FBODY = 4'd5,
    PH_CID   = 4'd6,
    PH_CSIZE = 4'd7,
    PH_SKIP  = 4'd8,
    PH_DATA  = 4'd9,
    PH_DONE  = 4'd10,
    PH_ERR   = 4'd11
  } phase_t;

  // per-byte status codes
  typedef enum logic [2:0] {
    ST_HEADER      = 3'd0,
    ST_PAYLOAD     = 3'd1,
    ST_BAD_RIFF    = 3'd2,
    ST_BAD_WAVE    = 3'd3,
    ST_BAD_FMT     = 3'd4,
    ST_UNSUPPORTED = 3'd5,
    ST_ERR_IDLE    = 3'd6
  } status_t;

  // audio format codes
  localparam logic [1:0] FMT_MONO8    = 2'd0;
  localparam logic [1:0] FMT_STEREO8  = 2'd1;
  localparam logic [1:0] FMT_MONO16   = 2'd2;
  localparam logic [1:0] FMT_STEREO16 = 2'd3;

  // channels + bits per sample for each supported format
  localparam logic [16:0] SUM_MONO8    = 17'd9;
  localparam logic [16:0] SUM_STEREO8  = 17'd10;
  localparam logic [16:0] SUM_MONO16   = 17'd17;
  localparam logic [16:0] SUM_STEREO16 = 17'd18;

  // chunk tags as little-endian words
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  // fmt body layout
  localparam logic [31:0] FMT_MIN_SIZE = 32'd16;
  localparam logic [31:0] OFS_CH_LO    = 32'd2;
  localparam logic [31:0] OFS_CH_HI    = 32'd3;
  localparam logic [31:0] OFS_RATE_B0  = 32'd4;
  localparam logic [31:0] OFS_RATE_B1  = 32'd5;
  localparam logic [31:0] OFS_RATE_B2  = 32'd6;
  localparam logic [31:0] OFS_RATE_B3  = 32'd7;
  localparam logic [31:0] OFS_BITS_LO  = 32'd14;
  localparam logic [31:0] OFS_BITS_HI  = 32'd15;

  typedef struct packed {
    status_t     status;
    logic [7:0]  payload_byte;
    logic        payload_last;
    logic [1:0]  audio_format;
    logic [31:0] sample_rate;
    logic [31:0] payload_size;
  } whp_result_t;

endpackage

>>> src/whp_in_if.sv
interface whp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_of_file;

  modport source (output valid, output in_byte, output start_of_file, input ready);
  modport sink (input valid, input in_byte, input start_of_file, output ready);
endinterface

>>> src/whp_out_if.sv
interface whp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  payload_byte;
  logic        payload_last;
  logic [1:0]  audio_format;
  logic [31:0] sample_rate;
  logic [31:0] payload_size;

  modport source (
    output valid, output status, output payload_byte, output payload_last,
    output audio_format, output sample_rate, output payload_size, input ready
  );
  modport sink (
    input valid, input status, input payload_byte, input payload_last,
    input audio_format, input sample_rate, input payload_size, output ready
  );
endinterface

>>> src/whp_parser.sv
module whp_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          in_byte,
  input  logic                start_of_file,
  output whp_pkg::whp_result_t result
);
  import whp_pkg::*;

  phase_t      phase, phase_next;
  logic [31:0] byte_count, byte_count_next;
  logic [31:0] word_shift, word_shift_next;
  logic [31:0] fmt_size, fmt_size_next;
  logic [15:0] channel_count, channel_count_next;
  logic [15:0] sample_bits, sample_bits_next;
  logic [31:0] rate_reg, rate_reg_next;
  logic [31:0] chunk_tag, chunk_tag_next;
  logic [31:0] chunk_remaining, chunk_remaining_next;
  logic [1:0]  format_reg, format_reg_next;

  // state as seen by this byte: a start flag restarts from reset values
  phase_t      e_phase;
  logic [31:0] e_count, e_word, e_fsize, e_rate, e_tag, e_rem;
  logic [15:0] e_ch, e_bits;
  logic [1:0]  e_fmt;

  assign e_phase = start_of_file ? PH_RIFF : phase;
  assign e_count = start_of_file ? 32'd0 : byte_count;
  assign e_word  = start_of_file ? 32'd0 : word_shift;
  assign e_fsize = start_of_file ? 32'd0 : fmt_size;
  assign e_ch    = start_of_file ? 16'd0 : channel_count;
  assign e_bits  = start_of_file ? 16'd0 : sample_bits;
  assign e_rate  = start_of_file ? 32'd0 : rate_reg;
  assign e_tag   = start_of_file ? 32'd0 : chunk_tag;
  assign e_rem   = start_of_file ? 32'd0 : chunk_remaining;
  assign e_fmt   = start_of_file ? FMT_MONO8 : format_reg;

  // shifters and counters shared by the phases
  logic [31:0] tag_in, word_in, quad_count, body_count, rem_dec;
  logic        quad_done;

  assign tag_in     = {in_byte, e_tag[31:8]};
  assign word_in    = {in_byte, e_word[31:8]};
  assign quad_done  = (e_count[1:0] == 2'd3);
  assign quad_count = {30'd0, e_count[1:0] + 2'd1};
  assign body_count = e_count + 32'd1;
  assign rem_dec    = e_rem - 32'd1;

  // fmt body field capture by byte offset
  logic [15:0] ch_cap, bits_cap;
  logic [31:0] rate_cap;
  logic [16:0] fmt_sum;

  always_comb begin
    ch_cap   = e_ch;
    bits_cap = e_bits;
    rate_cap = e_rate;
    case (e_count)
      OFS_CH_LO:   ch_cap = {e_ch[15:8], in_byte};
      OFS_CH_HI:   ch_cap = {in_byte, e_ch[7:0]};
      OFS_RATE_B0: rate_cap = {e_rate[31:8], in_byte};
      OFS_RATE_B1: rate_cap = {e_rate[31:16], in_byte, e_rate[7:0]};
      OFS_RATE_B2: rate_cap = {e_rate[31:24], in_byte, e_rate[15:0]};
      OFS_RATE_B3: rate_cap = {in_byte, e_rate[23:0]};
      OFS_BITS_LO: bits_cap = {e_bits[15:8], in_byte};
      OFS_BITS_HI: bits_cap = {in_byte, e_bits[7:0]};
      default: ;
    endcase
  end

  assign fmt_sum = {1'b0, ch_cap} + {1'b0, bits_cap};

  // per-byte phase step
  always_comb begin
    phase_next           = e_phase;
    byte_count_next      = e_count;
    word_shift_next      = e_word;
    fmt_size_next        = e_fsize;
    channel_count_next   = e_ch;
    sample_bits_next     = e_bits;
    rate_reg_next        = e_rate;
    chunk_tag_next       = e_tag;
    chunk_remaining_next = e_rem;
    format_reg_next      = e_fmt;
    result.status        = ST_HEADER;
    result.payload_byte  = 8'd0;
    result.payload_last  = 1'b0;
    case (e_phase)
      PH_RIFF, PH_WAVE, PH_FMT: begin
        chunk_tag_next  = tag_in;
        byte_count_next = quad_count;
        if (quad_done) begin
          if (e_phase == PH_RIFF) begin
            if (tag_in == TAG_RIFF) begin
              phase_next = PH_RSIZE;
            end else begin
              result.status = ST_BAD_RIFF;
              phase_next    = PH_ERR;
            end
          end else if (e_phase == PH_WAVE) begin
            if (tag_in == TAG_WAVE) begin
              phase_next = PH_FMT;
            end else begin
              result.status = ST_BAD_WAVE;
              phase_next    = PH_ERR;
            end
          end else begin
            if (tag_in == TAG_FMT) begin
              phase_next = PH_FSIZE;
            end else begin
              result.status = ST_BAD_FMT;
              phase_next    = PH_ERR;
            end
          end
        end
      end
      PH_RSIZE: begin
        word_shift_next = word_in;
        byte_count_next = quad_count;
        if (quad_done) begin
          phase_next = PH_WAVE;
        end
      end
      PH_FSIZE: begin
        word_shift_next = word_in;
        byte_count_next = quad_count;
        if (quad_done) begin
          fmt_size_next = word_in;
          if (word_in < FMT_MIN_SIZE) begin
            result.status = ST_BAD_FMT;
            phase_next    = PH_ERR;
          end else begin
            phase_next = PH_FBODY;
          end
        end
      end
      PH_FBODY: begin
        channel_count_next = ch_cap;
        sample_bits_next   = bits_cap;
        rate_reg_next      = rate_cap;
        byte_count_next    = body_count;
        if (body_count == e_fsize) begin
          byte_count_next = 32'd0;
          phase_next      = PH_CID;
          case (fmt_sum)
            SUM_MONO8:    format_reg_next = FMT_MONO8;
            SUM_STEREO8:  format_reg_next = FMT_STEREO8;
            SUM_MONO16:   format_reg_next = FMT_MONO16;
            SUM_STEREO16: format_reg_next = FMT_STEREO16;
            default: begin
              result.status = ST_UNSUPPORTED;
              phase_next    = PH_ERR;
            end
          endcase
        end
      end
      PH_CID: begin
        chunk_tag_next  = tag_in;
        byte_count_next = quad_count;
        if (quad_done) begin
          phase_next = PH_CSIZE;
        end
      end
      PH_CSIZE: begin
        word_shift_next = word_in;
        byte_count_next = quad_count;
        if (quad_done) begin
          chunk_remaining_next = word_in;
          if (e_tag == TAG_DATA) begin
            phase_next = (word_in == 32'd0) ? PH_DONE : PH_DATA;
          end else begin
            phase_next = (word_in == 32'd0) ? PH_CID : PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        chunk_remaining_next = rem_dec;
        if (rem_dec == 32'd0) begin
          phase_next = PH_CID;
        end
      end
      PH_DATA: begin
        result.status        = ST_PAYLOAD;
        result.payload_byte  = in_byte;
        chunk_remaining_next = rem_dec;
        if (rem_dec == 32'd0) begin
          result.payload_last = 1'b1;
          phase_next          = PH_DONE;
        end
      end
      PH_DONE: ;
      default: begin
        result.status = ST_ERR_IDLE;
        phase_next    = PH_ERR;
      end
    endcase

    // visible fields follow the updated state
    result.audio_format = format_reg_next;
    result.sample_rate  = rate_reg_next;
    result.payload_size =
      (phase_next == PH_DATA || phase_next == PH_DONE) ? word_shift_next : 32'd0;
  end

  // state registers, advanced once per transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_RIFF;
      byte_count      <= 32'd0;
      word_shift      <= 32'd0;
      fmt_size        <= 32'd0;
      channel_count   <= 16'd0;
      sample_bits     <= 16'd0;
      rate_reg        <= 32'd0;
      chunk_tag       <= 32'd0;
      chunk_remaining <= 32'd0;
      format_reg      <= FMT_MONO8;
    end else if (step) begin
      phase           <= phase_next;
      byte_count      <= byte_count_next;
      word_shift      <= word_shift_next;
      fmt_size        <= fmt_size_next;
      channel_count   <= channel_count_next;
      sample_bits     <= sample_bits_next;
      rate_reg        <= rate_reg_next;
      chunk_tag       <= chunk_tag_next;
      chunk_remaining <= chunk_remaining_next;
      format_reg      <= format_reg_next;
    end
  end

endmodule

>>> src/wav_header_parser_core.sv
// WAV header parser: takes a WAV file one byte per transfer and returns one
// result per byte.
// in_ch carries in_byte and start_of_file; start_of_file restarts the parser
// on that byte. out_ch carries status, payload_byte, payload_last,
// audio_format, sample_rate and payload_size. Both are valid/ready channels;
// a transfer happens when valid and ready are both high.
// A byte accepted into the input register is parsed into the result register
// once that register is free, and its result is held there until taken.
// Throughput: one byte per cycle while out_ch is not held off. The single
// parse step between the input register and the result register updates all parser state for a byte.
// Reset: rst (synchronous) empties both registers and returns the parser to
// the RIFF tag phase with all captured fields cleared.
// Stall: while out_ch is held off, the result register keeps its item and the
// input register still takes one more byte; after that in_ch.ready drops
// until the result is taken. Nothing is dropped or repeated.
module wav_header_parser_core (
  input logic      clk,
  input logic      rst,
  whp_in_if.sink   in_ch,
  whp_out_if.source out_ch
);
  import whp_pkg::*;

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        sof_q;
  logic        out_valid_q;
  whp_result_t result_q;
  whp_result_t step_result;
  logic        advance;

  // parse step moves the held byte when the result register is free
  assign advance     = in_valid_q && (!out_valid_q || out_ch.ready);
  assign in_ch.ready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_q <= in_ch.in_byte;
      sof_q     <= in_ch.start_of_file;
    end
  end

  whp_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .in_byte       (in_byte_q),
    .start_of_file (sof_q),
    .result        (step_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_q <= step_result;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.status       = result_q.status;
  assign out_ch.payload_byte = result_q.payload_byte;
  assign out_ch.payload_last = result_q.payload_last;
  assign out_ch.audio_format = result_q.audio_format;
  assign out_ch.sample_rate  = result_q.sample_rate;
  assign out_ch.payload_size = result_q.payload_size;

  // a last marker only ever comes with a payload byte
  a_last_on_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid_q && result_q.payload_last |-> result_q.status == ST_PAYLOAD)
    else $error("payload_last without payload status");

  // an empty result register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid_q |-> in_ch.ready)
    else $error("input stalled with empty result register");

  // every parse step lands in the result register
  a_step_lands: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid_q)
    else $error("parse step result lost");

  // payload byte reads zero outside payload results
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid_q && result_q.status != ST_PAYLOAD |-> result_q.payload_byte == 8'd0)
    else $error("payload byte set outside payload");

endmodule

>>> tb/sv/wav_header_parser_core_test.sv
module wav_header_parser_core_test;
  import whp_pkg::*;

  typedef struct packed {
    logic [7:0]  in_byte;
    logic        sof;
    logic        typed;
    whp_result_t want;
  } stim_row_t;

  logic clk;
  logic rst = 1'b1;

  whp_in_if  in_ch();
  whp_out_if out_ch();

  wav_header_parser_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // expected per-byte results, oldest first
  whp_result_t pending_results[$];
  stim_row_t   directed_rows[$];
  logic [7:0]  file_bytes[$];
  int unsigned mismatch_count = 0;
  int unsigned parsed_bytes = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;

  // parser state mirror
  phase_t      ph;
  logic [31:0] field_pos;
  logic [31:0] size_shift;
  logic [31:0] fmt_len;
  logic [31:0] rate_val;
  logic [31:0] tag_shift;
  logic [31:0] remaining;
  logic [15:0] chan_cnt;
  logic [15:0] bits_cnt;
  logic [1:0]  fmt_code;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    #2_000_000;
    $display("FAIL wav_header_parser_core");
    $finish;
  end

  function automatic void clear_parser();
    ph = PH_RIFF;
    field_pos = '0;
    size_shift = '0;
    fmt_len = '0;
    rate_val = '0;
    tag_shift = '0;
    remaining = '0;
    chan_cnt = '0;
    bits_cnt = '0;
    fmt_code = FMT_MONO8;
  endfunction

  // count one byte of a 4-byte field; true when the field is complete
  function automatic logic word_full();
    field_pos = (field_pos + 32'd1) & 32'd3;
    return field_pos == 32'd0;
  endfunction

  // advance the parser mirror by one byte and return its result
  function automatic whp_result_t wav_parse_byte(logic [7:0] b, logic sof);
    whp_result_t r;
    logic [16:0] sum;
    r = '0;
    r.status = ST_HEADER;
    if (sof) clear_parser();
    case (ph)
      PH_RIFF: begin
        tag_shift = {b, tag_shift[31:8]};
        if (word_full()) begin
          if (tag_shift == TAG_RIFF) ph = PH_RSIZE;
          else begin
            r.status = ST_BAD_RIFF;
            ph = PH_ERR;
          end
        end
      end
      PH_RSIZE: begin
        size_shift = {b, size_shift[31:8]};
        if (word_full()) ph = PH_WAVE;
      end
      PH_WAVE: begin
        tag_shift = {b, tag_shift[31:8]};
        if (word_full()) begin
          if (tag_shift == TAG_WAVE) ph = PH_FMT;
          else begin
            r.status = ST_BAD_WAVE;
            ph = PH_ERR;
          end
        end
      end
      PH_FMT: begin
        tag_shift = {b, tag_shift[31:8]};
        if (word_full()) begin
          if (tag_shift == TAG_FMT) ph = PH_FSIZE;
          else begin
            r.status = ST_BAD_FMT;
            ph = PH_ERR;
          end
        end
      end
      PH_FSIZE: begin
        size_shift = {b, size_shift[31:8]};
        if (word_full()) begin
          fmt_len = size_shift;
          if (fmt_len < FMT_MIN_SIZE) begin
            r.status = ST_BAD_FMT;
            ph = PH_ERR;
          end else begin
            ph = PH_FBODY;
          end
        end
      end
      PH_FBODY: begin
        // capture channels, rate and bits at their fixed offsets
        case (field_pos)
          OFS_CH_LO:   chan_cnt[7:0] = b;
          OFS_CH_HI:   chan_cnt[15:8] = b;
          OFS_RATE_B0: rate_val[7:0] = b;
          OFS_RATE_B1: rate_val[15:8] = b;
          OFS_RATE_B2: rate_val[23:16] = b;
          OFS_RATE_B3: rate_val[31:24] = b;
          OFS_BITS_LO: bits_cnt[7:0] = b;
          OFS_BITS_HI: bits_cnt[15:8] = b;
          default: ;
        endcase
        field_pos = field_pos + 32'd1;
        if (field_pos == fmt_len) begin
          sum = {1'b0, chan_cnt} + {1'b0, bits_cnt};
          field_pos = '0;
          ph = PH_CID;
          case (sum)
            SUM_MONO8:    fmt_code = FMT_MONO8;
            SUM_STEREO8:  fmt_code = FMT_STEREO8;
            SUM_MONO16:   fmt_code = FMT_MONO16;
            SUM_STEREO16: fmt_code = FMT_STEREO16;
            default: begin
              r.status = ST_UNSUPPORTED;
              ph = PH_ERR;
            end
          endcase
        end
      end
      PH_CID: begin
        tag_shift = {b, tag_shift[31:8]};
        if (word_full()) ph = PH_CSIZE;
      end
      PH_CSIZE: begin
        size_shift = {b, size_shift[31:8]};
        if (word_full()) begin
          remaining = size_shift;
          if (tag_shift == TAG_DATA) ph = (remaining == '0) ? PH_DONE : PH_DATA;
          else ph = (remaining == '0) ? PH_CID : PH_SKIP;
        end
      end
      PH_SKIP: begin
        remaining = remaining - 32'd1;
        if (remaining == '0) ph = PH_CID;
      end
      PH_DATA: begin
        r.status = ST_PAYLOAD;
        r.payload_byte = b;
        remaining = remaining - 32'd1;
        if (remaining == '0) begin
          r.payload_last = 1'b1;
          ph = PH_DONE;
        end
      end
      PH_DONE: ;
      default: begin
        r.status = ST_ERR_IDLE;
        ph = PH_ERR;
      end
    endcase
    r.audio_format = fmt_code;
    r.sample_rate = rate_val;
    r.payload_size = (ph == PH_DATA || ph == PH_DONE) ? size_shift : '0;
    return r;
  endfunction

  function automatic stim_row_t stim_row(logic [7:0] b, logic sof, logic typed, status_t st);
    stim_row_t r;
    r = '0;
    r.in_byte = b;
    r.sof = sof;
    r.typed = typed;
    r.want.status = st;
    return r;
  endfunction

  // append a little-endian field to the file being built
  function automatic void put_le(logic [31:0] v, int unsigned nbytes);
    for (int k = 0; k < nbytes; k++) file_bytes.push_back(v[8*k +: 8]);
  endfunction

  // build one random file: mostly well formed, some flawed, some noise
  function automatic void compose_file();
    int unsigned kind;
    int unsigned pick;
    int unsigned big_field;
    int unsigned fmt_extra;
    int unsigned len;
    int unsigned idx;
    logic [31:0] short_len;
    logic [31:0] rate;
    logic [31:0] tag;
    logic [15:0] chan;
    logic [15:0] bits;
    file_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind >= 95) begin
      repeat ($urandom_range(1, 16)) file_bytes.push_back(8'($urandom));
      return;
    end
    // some files declare a random size that the written bytes do not follow
    big_field = (kind >= 88) ? $urandom_range(0, 2) : 3;

    put_le(TAG_RIFF, 4);
    put_le($urandom, 4);
    put_le(TAG_WAVE, 4);
    put_le(TAG_FMT, 4);
    fmt_extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    put_le((big_field == 0) ? $urandom : 32'(16 + fmt_extra), 4);

    // fmt body
    pick = $urandom_range(0, 9);
    if (pick < 8) begin
      chan = 16'($urandom_range(1, 2));
      bits = $urandom_range(0, 1) ? 16'd16 : 16'd8;
    end else if (pick == 8) begin
      chan = 16'($urandom_range(0, 18));
      bits = 16'($urandom_range(0, 18));
    end else begin
      chan = 16'($urandom);
      bits = 16'($urandom);
    end
    case ($urandom_range(0, 3))
      0: rate = '0;
      1: rate = '1;
      2: rate = 32'd44100;
      default: rate = $urandom;
    endcase
    put_le($urandom_range(0, 1) ? 32'd1 : $urandom, 2);
    put_le(32'(chan), 2);
    put_le(rate, 4);
    put_le($urandom, 4);
    put_le($urandom, 2);
    put_le(32'(bits), 2);
    repeat (fmt_extra) file_bytes.push_back(8'($urandom));

    // chunks to skip, odd and empty sizes included
    repeat ($urandom_range(0, 2)) begin
      tag = $urandom;
      if (tag == TAG_DATA) tag[0] = ~tag[0];
      len = $urandom_range(0, 5);
      put_le(tag, 4);
      put_le((big_field == 1) ? $urandom : 32'(len), 4);
      repeat (len) file_bytes.push_back(8'($urandom));
    end

    // data chunk, then a few bytes past its end
    len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 16);
    put_le(TAG_DATA, 4);
    put_le((big_field == 2) ? $urandom : 32'(len), 4);
    repeat (len) file_bytes.push_back(8'($urandom));
    repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom));

    // inject one header flaw
    if (kind >= 70 && kind < 88) begin
      case ($urandom_range(0, 4))
        0: idx = $urandom_range(0, 3);
        1: idx = $urandom_range(8, 11);
        2: idx = $urandom_range(12, 15);
        default: idx = 0;
      endcase
      pick = $urandom_range(0, 4);
      if (pick < 3) begin
        file_bytes[idx] = file_bytes[idx] ^ 8'($urandom_range(1, 255));
      end else if (pick == 3) begin
        short_len = 32'($urandom_range(0, 15));
        for (int k = 0; k < 4; k++) file_bytes[16 + k] = short_len[8*k +: 8];
      end else begin
        // high channel byte forces an unsupported sum
        file_bytes[23] = 8'($urandom_range(1, 255));
      end
    end
  endfunction

  // one input transfer after a random gap, then record its expected result
  task automatic send_byte(input logic [7:0] b, input logic sof, input logic typed,
                           input whp_result_t typed_result);
    int unsigned gap;
    logic was_done;
    whp_result_t predicted;
    if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.start_of_file <= sof;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    was_done = (ph == PH_DONE) && !sof;
    predicted = wav_parse_byte(b, sof);
    if (!was_done && predicted.status != ST_ERR_IDLE) parsed_bytes++;
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // result side: random stalls, compare each transfer with the oldest expectation
  initial begin : result_sink
    int unsigned stall;
    whp_result_t want;
    out_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      stall = out_calm ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      if (pending_results.size() == 0) begin
        $error("result with no byte pending: status %0d", out_ch.status);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, out_ch.status);
        check_field("payload_byte", want.payload_byte, out_ch.payload_byte);
        check_field("payload_last", want.payload_last, out_ch.payload_last);
        check_field("audio_format", want.audio_format, out_ch.audio_format);
        check_field("sample_rate", want.sample_rate, out_ch.sample_rate);
        check_field("payload_size", want.payload_size, out_ch.payload_size);
      end
    end
  end

  initial begin : stimulus
    in_ch.valid <= 1'b0;
    in_ch.in_byte <= '0;
    in_ch.start_of_file <= 1'b0;
    clear_parser();

    directed_rows = '{
      // bad RIFF tag, then error idle on both byte extremes
      stim_row("R", 1'b1, 1'b1, ST_HEADER),
      stim_row("I", 1'b0, 1'b0, ST_HEADER),
      stim_row("F", 1'b0, 1'b0, ST_HEADER),
      stim_row("X", 1'b0, 1'b1, ST_BAD_RIFF),
      stim_row(8'h00, 1'b0, 1'b1, ST_ERR_IDLE),
      stim_row(8'hFF, 1'b0, 1'b1, ST_ERR_IDLE),
      // restart out of error idle, all-ones RIFF size, bad WAVE tag
      stim_row("R", 1'b1, 1'b1, ST_HEADER),
      stim_row("I", 1'b0, 1'b0, ST_HEADER),
      stim_row("F", 1'b0, 1'b0, ST_HEADER),
      stim_row("F", 1'b0, 1'b0, ST_HEADER),
      stim_row(8'hFF, 1'b0, 1'b0, ST_HEADER),
      stim_row(8'hFF, 1'b0, 1'b0, ST_HEADER),
      stim_row(8'hFF, 1'b0, 1'b0, ST_HEADER),
      stim_row(8'hFF, 1'b0, 1'b0, ST_HEADER),
      stim_row("W", 1'b0, 1'b0, ST_HEADER),
      stim_row("A", 1'b0, 1'b0, ST_HEADER),
      stim_row("V", 1'b0, 1'b0, ST_HEADER),
      stim_row("F", 1'b0, 1'b1, ST_BAD_WAVE),
      stim_row(8'h55, 1'b0, 1'b1, ST_ERR_IDLE),
      // restart, then cut off in the middle of the RIFF size
      stim_row("R", 1'b1, 1'b1, ST_HEADER),
      stim_row("I", 1'b0, 1'b0, ST_HEADER),
      stim_row("F", 1'b0, 1'b0, ST_HEADER),
      stim_row("F", 1'b0, 1'b0, ST_HEADER),
      stim_row(8'h00, 1'b0, 1'b0, ST_HEADER),
      stim_row(8'h00, 1'b0, 1'b0, ST_HEADER),
      stim_row(8'h00, 1'b0, 1'b0, ST_HEADER)
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].in_byte, directed_rows[i].sof, directed_rows[i].typed,
                directed_rows[i].want);
    end

    // random files, each one opened with a restart
    while (parsed_bytes < 1300) begin
      compose_file();
      foreach (file_bytes[i]) send_byte(file_bytes[i], i == 0, 1'b0, '0);
    end

    // drop valid at the last transfer and drain
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS wav_header_parser_core");
    end else begin
      $display("FAIL wav_header_parser_core");
    end
    $finish;
  end

endmodule
